// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mtrr range splitter check failed");

// Check a property on every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mtrr range splitter check failed");

`endif

// ===== rtl/core/mrs_pkg.sv =====
// Types, constants, microcode table and helpers of the MTRR range splitter.
package mrs_pkg;

  // Field widths
  localparam int AddrW     = 36;
  localparam int SizeW     = 32;
  localparam int TypeW     = 8;
  localparam int IdxW      = 4;
  localparam int PgFieldW  = 24;
  localparam int CntW      = 5;
  localparam int PageShift = 12;

  // Page count of a request: at most 2^20, so 21 bits
  localparam int RemW   = SizeW - PageShift + 1;
  localparam int AlignW = RemW + 1;

  // Entry count limits
  localparam int MaxOut        = 16;
  localparam int VarCountReset = 8;

  // Defaults of the top-level parameters
  localparam int DefMaxVarRanges = 16;
  localparam int DefPageBits     = 24;

  // Sequencer steps
  localparam logic [1:0] STEP_IDLE    = 2'd0;
  localparam logic [1:0] STEP_SETUP   = 2'd1;
  localparam logic [1:0] STEP_EMIT    = 2'd2;
  localparam logic [1:0] STEP_SPECIAL = 2'd3;

  // Branch conditions
  localparam logic [1:0] COND_ACCEPT  = 2'd0;
  localparam logic [1:0] COND_TRIVIAL = 2'd1;
  localparam logic [1:0] COND_DONE    = 2'd2;
  localparam logic [1:0] COND_ALWAYS  = 2'd3;

  typedef struct packed {
    logic       rdy;
    logic       load;
    logic       setup;
    logic       emit_entry;
    logic       emit_special;
    logic       wait_out;
    logic [1:0] cond;
    logic [1:0] jt;
    logic [1:0] jf;
  } ucode_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic setup;
    logic emit_entry;
    logic emit_special;
  } mrs_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic slot_free;
    logic trivial;
    logic done;
  } mrs_stat_t;

  // Control program: one word per step
  function automatic ucode_t ucode_rom(input logic [1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.rdy  = 1'b1;
        w.load = 1'b1;
        w.cond = COND_ACCEPT;
        w.jt   = STEP_SETUP;
        w.jf   = STEP_IDLE;
      end
      STEP_SETUP: begin
        w.setup = 1'b1;
        w.cond  = COND_TRIVIAL;
        w.jt    = STEP_SPECIAL;
        w.jf    = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit_entry = 1'b1;
        w.wait_out   = 1'b1;
        w.cond       = COND_DONE;
        w.jt         = STEP_IDLE;
        w.jf         = STEP_EMIT;
      end
      STEP_SPECIAL: begin
        w.emit_special = 1'b1;
        w.wait_out     = 1'b1;
        w.cond         = COND_ALWAYS;
        w.jt           = STEP_IDLE;
        w.jf           = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Largest power of two not above v (v nonzero): smear ones down, keep the top
  function automatic logic [RemW-1:0] mrs_hibit(input logic [RemW-1:0] v);
    logic [RemW-1:0] p;
    p = v;
    for (int s = 1; s < RemW; s = s * 2) begin
      p = p | (p >> s);
    end
    return p & ~(p >> 1);
  endfunction

endpackage

// ===== rtl/core/mrs_if.sv =====
// Channel interfaces of the MTRR range splitter: request, entry result, configuration.
interface mrs_req_if;
  import mrs_pkg::*;
  logic                valid;
  logic                ready;
  logic [AddrW-1:0]    base_addr;
  logic [SizeW-1:0]    size_bytes;
  logic [TypeW-1:0]    mem_attr;
  modport source (output valid, base_addr, size_bytes, mem_attr, input ready);
  modport sink   (input valid, base_addr, size_bytes, mem_attr, output ready);
endinterface

interface mrs_rsp_if;
  import mrs_pkg::*;
  logic                valid;
  logic                ready;
  logic [IdxW-1:0]     entry_index;
  logic [PgFieldW-1:0] base_page;
  logic [PgFieldW-1:0] mask_page;
  logic [TypeW-1:0]    type_out;
  logic                entry_valid;
  logic                last;
  logic                failed;
  modport source (output valid, entry_index, base_page, mask_page, type_out,
                  entry_valid, last, failed, input ready);
  modport sink   (input valid, entry_index, base_page, mask_page, type_out,
                  entry_valid, last, failed, output ready);
endinterface

interface mrs_cfg_if;
  import mrs_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/mrs_sequencer.sv =====
// Microcoded step sequencer: program counter, control word fetch and branching.
module mrs_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  mrs_pkg::mrs_stat_t stat,
  output mrs_pkg::mrs_ctrl_t ctrl
);
  import mrs_pkg::*;

  logic [1:0] step;
  logic [1:0] step_next;
  ucode_t     word;
  logic       fire;
  logic       cond_hit;

  assign word = ucode_rom(step);
  // An output step waits for a free result slot
  assign fire = !word.wait_out || stat.slot_free;

  always_comb begin
    unique case (word.cond)
      COND_ACCEPT:  cond_hit = stat.in_valid;
      COND_TRIVIAL: cond_hit = stat.trivial;
      COND_DONE:    cond_hit = stat.done;
      COND_ALWAYS:  cond_hit = 1'b1;
    endcase
  end

  assign step_next = fire ? (cond_hit ? word.jt : word.jf) : step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.in_ready     = word.rdy;
  assign ctrl.load         = word.load && stat.in_valid;
  assign ctrl.setup        = word.setup;
  assign ctrl.emit_entry   = word.emit_entry && stat.slot_free;
  assign ctrl.emit_special = word.emit_special && stat.slot_free;

endmodule

// ===== rtl/core/mrs_datapath.sv =====
// Datapath: request registers, chunk selection, entry counter and result register.
module mrs_datapath #(
  parameter int MAX_VAR_RANGES = mrs_pkg::DefMaxVarRanges,
  parameter int PAGE_BITS      = mrs_pkg::DefPageBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mrs_pkg::mrs_ctrl_t            ctrl,
  output mrs_pkg::mrs_stat_t            stat,
  input  logic                          req_valid,
  input  logic [mrs_pkg::AddrW-1:0]     base_addr,
  input  logic [mrs_pkg::SizeW-1:0]     size_bytes,
  input  logic [mrs_pkg::TypeW-1:0]     mem_attr,
  input  logic                          cfg_we,
  input  logic [mrs_pkg::CntW-1:0]      cfg_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [mrs_pkg::IdxW-1:0]      entry_index,
  output logic [mrs_pkg::PgFieldW-1:0]  base_page,
  output logic [mrs_pkg::PgFieldW-1:0]  mask_page,
  output logic [mrs_pkg::TypeW-1:0]     type_out,
  output logic                          entry_valid,
  output logic                          last,
  output logic                          failed
);
  import mrs_pkg::*;

  localparam int CapCnt = (MAX_VAR_RANGES < MaxOut) ? MAX_VAR_RANGES : MaxOut;

  logic [CntW-1:0]      var_count;
  logic [RemW-1:0]      rem;
  logic [AlignW-1:0]    align;
  logic [PgFieldW-1:0]  base_pg;
  logic                 low_nz;
  logic [PAGE_BITS-1:0] page;
  logic [TypeW-1:0]     mtype;
  logic [IdxW-1:0]      n;

  logic [CntW-1:0]      cnt_eff;
  logic [PgFieldW-1:0]  lsb;
  logic                 align_big;
  logic [AlignW-1:0]    align_next;
  logic                 use_align;
  logic [RemW-1:0]      chunk;
  logic [RemW-1:0]      rem_left;
  logic                 last_slot;
  logic                 done;
  logic [PAGE_BITS-1:0] chunk_pg;
  logic [PAGE_BITS-1:0] mask_pg;

  assign cnt_eff = (var_count > CntW'(CapCnt)) ? CntW'(CapCnt) : var_count;

  // Alignment chunk: lowest set page bit of the base, one page if any low byte bit is set
  assign lsb       = base_pg & (~base_pg + PgFieldW'(1));
  assign align_big = (base_pg == '0) || (|lsb[PgFieldW-1:RemW]);
  always_comb begin
    if (low_nz) begin
      align_next = AlignW'(1);
    end else if (align_big) begin
      align_next = {1'b1, {RemW{1'b0}}};
    end else begin
      align_next = {1'b0, lsb[RemW-1:0]};
    end
  end

  assign use_align = {1'b0, rem} >= align;
  assign chunk     = use_align ? align[RemW-1:0] : mrs_hibit(rem);
  assign rem_left  = rem - chunk;
  assign last_slot = (CntW'(n) + CntW'(1)) == cnt_eff;
  assign done      = (rem_left == '0) || last_slot;
  assign chunk_pg  = PAGE_BITS'(chunk);
  assign mask_pg   = ~(chunk_pg - PAGE_BITS'(1));

  assign stat.in_valid  = req_valid;
  assign stat.slot_free = !rsp_valid || rsp_ready;
  assign stat.trivial   = (rem == '0) || (cnt_eff == '0);
  assign stat.done      = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      var_count <= CntW'(VarCountReset);
    end else if (cfg_we) begin
      var_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit_entry || ctrl.emit_special) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem     <= {1'b0, size_bytes[SizeW-1:PageShift]} + RemW'(|size_bytes[PageShift-1:0]);
      base_pg <= base_addr[AddrW-1:PageShift];
      low_nz  <= |base_addr[PageShift-1:0];
      page    <= PAGE_BITS'(base_addr[AddrW-1:PageShift]);
      mtype   <= mem_attr;
    end
    if (ctrl.setup) begin
      align <= align_next;
      n     <= '0;
    end
    if (ctrl.emit_entry) begin
      rem         <= rem_left;
      page        <= page + chunk_pg;
      n           <= n + IdxW'(1);
      entry_index <= n;
      base_page   <= PgFieldW'(page);
      mask_page   <= PgFieldW'(mask_pg);
      type_out    <= mtype;
      entry_valid <= 1'b1;
      last        <= done;
      failed      <= done && (rem_left != '0);
    end
    if (ctrl.emit_special) begin
      entry_index <= '0;
      base_page   <= '0;
      mask_page   <= '0;
      type_out    <= '0;
      entry_valid <= 1'b0;
      last        <= 1'b1;
      failed      <= rem != '0;
    end
  end

endmodule

// ===== rtl/core/mtrr_range_splitter_core.sv =====
// Top level of the MTRR variable-range splitter.
//
//  Channel | Dir | Payload                                              | Accepted when
//  --------+-----+------------------------------------------------------+---------------------
//  req     | in  | base_addr, size_bytes, mem_attr                      | req.valid & req.ready
//  rsp     | out | entry_index, base_page, mask_page, type_out,         | rsp.valid & rsp.ready
//          |     | entry_valid, last, failed                            |
//  cfg     | in  | data (available variable-range entry count)          | cfg.valid & cfg.ready
//
// A request yields N results (1 to 16). The idle step accepts it; the set-up step works
// out the page count test and alignment chunk; then the emit step, from the single chunk
// select / subtract unit, yields one entry per cycle while the result slot is free.
// Reset clears the step counter and the result valid, and sets the entry count to 8.
// A stalled result holds the emit step; req is taken again once the last result is
// registered, even while it still waits on rsp. cfg is always ready.
module mtrr_range_splitter_core #(
  parameter int MAX_VAR_RANGES = mrs_pkg::DefMaxVarRanges,
  parameter int PAGE_BITS      = mrs_pkg::DefPageBits
) (
  input  logic      clk,
  input  logic      rst,
  mrs_req_if.sink   req,
  mrs_rsp_if.source rsp,
  mrs_cfg_if.sink   cfg
);
  import mrs_pkg::*;

  mrs_ctrl_t ctrl;
  mrs_stat_t stat;

  // Configuration writes land directly in the entry count register
  assign cfg.ready = 1'b1;
  assign req.ready = ctrl.in_ready;

  // Step counter and control program
  mrs_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Request registers, chunk unit and result register
  mrs_datapath #(
    .MAX_VAR_RANGES (MAX_VAR_RANGES),
    .PAGE_BITS      (PAGE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .req_valid   (req.valid),
    .base_addr   (req.base_addr),
    .size_bytes  (req.size_bytes),
    .mem_attr    (req.mem_attr),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .entry_index (rsp.entry_index),
    .base_page   (rsp.base_page),
    .mask_page   (rsp.mask_page),
    .type_out    (rsp.type_out),
    .entry_valid (rsp.entry_valid),
    .last        (rsp.last),
    .failed      (rsp.failed)
  );

endmodule

// ===== rtl/core/mrs_checker.sv =====
// Port-level checks of the MTRR range splitter and their bind to the top level.
`include "assert_macros.svh"

module mrs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [mrs_pkg::IdxW-1:0]      entry_index,
  input logic [mrs_pkg::PgFieldW-1:0]  base_page,
  input logic [mrs_pkg::PgFieldW-1:0]  mask_page,
  input logic                          entry_valid,
  input logic                          last,
  input logic                          failed
);

  // Reset drops any pending result
  `ASSERT_ALWAYS(a_rst_clears, clk, rst |=> !rsp_valid)

  // An accepted request keeps the block busy for at least its set-up step
  `ASSERT_RST(a_busy_after_accept, clk, rst, req_valid && req_ready |=> !req_ready)

  // Failure is reported only on the closing result
  `ASSERT_RST(a_fail_is_last, clk, rst, rsp_valid && failed |-> last)

  // A result that programs no entry closes its request
  `ASSERT_RST(a_empty_is_last, clk, rst, rsp_valid && !entry_valid |-> last)

  // A stalled result holds
  `ASSERT_RST(a_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_index) && $stable(base_page) && $stable(mask_page) && $stable(last))

endmodule

bind mtrr_range_splitter_core mrs_checker u_mrs_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .entry_index (rsp.entry_index),
  .base_page   (rsp.base_page),
  .mask_page   (rsp.mask_page),
  .entry_valid (rsp.entry_valid),
  .last        (rsp.last),
  .failed      (rsp.failed)
);
